// ===== rtl/core/dtti64_pkg.sv =====
// ----------------------------------------------------------------------------
// dtti64_pkg
// Types and constants for the decimal text to signed 64-bit integer converter.
// ----------------------------------------------------------------------------
package dtti64_pkg;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic signed [63:0] parsed_value;
      logic               out_of_range;
   } rsp_type;

   typedef enum logic [1:0] {
      PH_SKIP    = 2'd0,
      PH_SIGNED  = 2'd1,
      PH_DIGITS  = 2'd2,
      PH_STOPPED = 2'd3
   } phase_type;

   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_PLUS  = 8'd43;
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;

   localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

endpackage

// ===== rtl/core/decimal_text_to_int64.sv =====
// ----------------------------------------------------------------------------
// decimal_text_to_int64
// Streaming base-10 text to signed 64-bit integer converter, one byte per
// transfer; skips leading whitespace, takes one sign, accumulates digits and
// flags overflow; one result per string on the byte marked end_of_text.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_data (text_byte, end_of_text)
//  rsp     | out       | rsp_valid/rsp_stall | rsp_data (parsed_value, out_of_range)
//
//  one byte per cycle while the result is not stalled; a byte moves from the input
//  register through the multiply-by-ten, add and limit compare into the parser state
//  the result is registered once its last byte advances out of the input register
//  reset returns the parser to whitespace skipping and empties both registers
//  a stalled result holds the last byte of the next string in the input register
// ----------------------------------------------------------------------------
module decimal_text_to_int64 (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  dtti64_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output dtti64_pkg::rsp_type rsp_data
);
   import dtti64_pkg::*;

   logic      s1_valid_ff, s1_valid_in;
   req_type   s1_req_ff, s1_req_in;
   phase_type phase_ff, phase_in;
   logic      neg_ff, neg_in;
   logic [63:0] mag_ff, mag_in;
   logic      ovf_ff, ovf_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_mag_ff, rsp_mag_in;
   logic      rsp_neg_ff, rsp_neg_in;
   logic      rsp_ovf_ff, rsp_ovf_in;

   logic        out_free, advance, is_last;
   logic [7:0]  c;
   logic        is_blank, is_digit, is_sign, take;
   logic [67:0] prod;
   logic [63:0] limit;
   logic        over;
   logic        neg_next;
   logic [63:0] mag_next;
   logic        ovf_next;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_last   = s1_req_ff.end_of_text;
   assign advance   = s1_valid_ff && (!is_last || out_free);
   assign req_stall = s1_valid_ff && !advance;

   assign c        = s1_req_ff.text_byte;
   assign is_blank = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign is_sign  = (c == CHAR_PLUS) || (c == CHAR_MINUS);
   assign limit    = neg_ff ? NEG_LIMIT : POS_LIMIT;
   assign prod     = {1'b0, mag_ff, 3'b000} + {3'b000, mag_ff, 1'b0}
                   + {64'd0, 4'(c - CHAR_ZERO)};
   assign over     = prod > {4'd0, limit};
   assign take     = is_digit && (phase_ff != PH_STOPPED);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (advance) begin
         case (phase_ff)
            PH_SKIP: begin
               if (is_blank) begin
                  phase_in = PH_SKIP;
               end else if (is_sign) begin
                  phase_in = PH_SIGNED;
               end else if (is_digit) begin
                  phase_in = over ? PH_STOPPED : PH_DIGITS;
               end else begin
                  phase_in = PH_STOPPED;
               end
            end
            PH_SIGNED, PH_DIGITS: begin
               if (is_digit) begin
                  phase_in = over ? PH_STOPPED : PH_DIGITS;
               end else begin
                  phase_in = PH_STOPPED;
               end
            end
            default: phase_in = phase_ff;
         endcase
         if (is_last) begin
            phase_in = PH_SKIP;
         end
      end
   end

   // accumulator and result
   always_comb begin
      neg_next = (phase_ff == PH_SKIP && is_sign) ? (c == CHAR_MINUS) : neg_ff;
      mag_next = (take && !over) ? prod[63:0] : mag_ff;
      ovf_next = ovf_ff || (take && over);

      neg_in       = neg_ff;
      mag_in       = mag_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_mag_in   = rsp_mag_ff;
      rsp_neg_in   = rsp_neg_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (advance) begin
         if (is_last) begin
            neg_in       = 1'b0;
            mag_in       = '0;
            ovf_in       = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_mag_in   = ovf_next ? '0 : mag_next;
            rsp_neg_in   = neg_next && !ovf_next;
            rsp_ovf_in   = ovf_next;
         end else begin
            neg_in = neg_next;
            mag_in = mag_next;
            ovf_in = ovf_next;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff && !advance;
      s1_req_in   = s1_req_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
         s1_req_in   = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         phase_ff     <= PH_SKIP;
         neg_ff       <= 1'b0;
         mag_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         mag_ff       <= mag_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff  <= s1_req_in;
      rsp_mag_ff <= rsp_mag_in;
      rsp_neg_ff <= rsp_neg_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_data.parsed_value = rsp_neg_ff ? (64'd0 - rsp_mag_ff) : rsp_mag_ff;
   assign rsp_data.out_of_range = rsp_ovf_ff;

   // string end clears the parser
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && is_last) |=> (phase_ff == PH_SKIP && mag_ff == 64'd0 && !ovf_ff && !neg_ff))
      else $error("parser state not cleared after last byte");

   a_ovf_stopped: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (phase_ff == PH_STOPPED))
      else $error("overflow without stopped phase");

   a_mag_bound: assert property (@(posedge clock) disable iff (reset)
      (mag_ff <= NEG_LIMIT) && (neg_ff || (mag_ff <= POS_LIMIT)))
      else $error("magnitude beyond limit");

   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_of_range) |-> (rsp_data.parsed_value == 64'sd0))
      else $error("overflow result not zero");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && is_last && rsp_valid_ff))
      else $error("input stalled without a waiting result");

endmodule
